// File: rtl/core/cfp_pkg.sv
// Package for the command frame parser: phase and register codes, the
// configuration and result structs, and the buffer depth. No dependencies.
package cfp_pkg;

  // Depth of the payload buffer behind the write port (1 to 256).
  localparam int unsigned BufferDepth = 64;

  typedef enum logic [1:0] {
    PH_CMD   = 2'd0,
    PH_COUNT = 2'd1,
    PH_DATA  = 2'd2,
    PH_FUNC  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    REG_DATA_CMD = 2'd0,
    REG_FUNC_CMD = 2'd1,
    REG_TIMEOUT  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  data_command_code;
    logic [7:0]  function_command_code;
    logic [15:0] idle_timeout_polls;
  } cfg_t;

  typedef struct packed {
    logic       write_valid;
    logic [7:0] write_index;
    logic [7:0] write_byte;
    logic       overrun;
    logic       invoke_valid;
    logic [7:0] function_id;
    logic [7:0] payload_count;
    logic       timeout_reset;
    phase_e     parser_phase;
  } res_t;

endpackage

// File: rtl/core/command_frame_parser.sv
// Top level of the command frame parser: input register, parser step logic,
// result register and configuration port. Depends on cfp_pkg and cfp_* modules.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+--------------------------
//   in      | into      | in_valid_i / in_stall_o    | kind_i, rx_byte_i
//   out     | out of    | out_valid_o / out_stall_i  | write_*, overrun, invoke,
//           |           |                            | timeout_reset, parser_phase
//   config  | into      | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// Every beat gives exactly one result beat. A beat is held in the input
// register, is processed by the step logic as it moves into the result
// register, and is offered on the next cycle; one beat per cycle is
// sustained when the output is not stalled.
// The rate is set by the single parser state update per cycle in cfp_step.
// Reset is asynchronous and active low; it empties both registers, returns
// the parser to the command phase and loads the register defaults.
// While the output stalls, one more beat is still taken into the input
// register; after that in_stall_o rises until the result beat is taken.
module command_frame_parser import cfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        write_valid_o,
  output logic [7:0]  write_index_o,
  output logic [7:0]  write_byte_o,
  output logic        overrun_o,
  output logic        invoke_valid_o,
  output logic [7:0]  function_id_o,
  output logic [7:0]  payload_count_o,
  output logic        timeout_reset_o,
  output logic [1:0]  parser_phase_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  res_t       step_res;
  res_t       out_res;
  logic       in_valid_q;
  logic       kind_q;
  logic [7:0] byte_q;
  logic       out_free;
  logic       advance;
  logic       in_take;

  // The held beat advances when the result register has room for it.
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take || advance) begin
      in_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q <= kind_i;
      byte_q <= rx_byte_i;
    end
  end

  cfp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cfp_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .kind_i    (kind_q),
    .rx_byte_i (byte_q),
    .cfg_i     (cfg),
    .res_o     (step_res)
  );

  cfp_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (step_res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .free_o      (out_free),
    .res_o       (out_res)
  );

  assign write_valid_o   = out_res.write_valid;
  assign write_index_o   = out_res.write_index;
  assign write_byte_o    = out_res.write_byte;
  assign overrun_o       = out_res.overrun;
  assign invoke_valid_o  = out_res.invoke_valid;
  assign function_id_o   = out_res.function_id;
  assign payload_count_o = out_res.payload_count;
  assign timeout_reset_o = out_res.timeout_reset;
  assign parser_phase_o  = out_res.parser_phase;

  a_one_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({write_valid_o, overrun_o, invoke_valid_o,
                                timeout_reset_o}) <= 1)
    else $error("more than one event in one result beat");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("processed beat missing from result register");

  a_full_pipe_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while both stages are full");

endmodule

// File: rtl/core/cfp_regs.sv
// Configuration registers of the command frame parser on an APB-style port.
// Depends on cfp_pkg for the register codes and the cfg_t struct.
module cfp_regs import cfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  logic       wr_en;
  reg_idx_e   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_DATA_CMD: cfg_d.data_command_code     = pwdata[7:0];
        REG_FUNC_CMD: cfg_d.function_command_code = pwdata[7:0];
        REG_TIMEOUT:  cfg_d.idle_timeout_polls    = pwdata[15:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DATA_CMD: prdata = {24'd0, cfg_q.data_command_code};
      REG_FUNC_CMD: prdata = {24'd0, cfg_q.function_command_code};
      REG_TIMEOUT:  prdata = {16'd0, cfg_q.idle_timeout_polls};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.data_command_code     <= 8'd0;
      cfg_q.function_command_code <= 8'd1;
      cfg_q.idle_timeout_polls    <= 16'd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/cfp_step.sv
// Parser state and the per-beat update logic of the command frame parser.
// Depends on cfp_pkg for phase codes, cfg_t, res_t and the buffer depth.
module cfp_step import cfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic       kind_i,
  input  logic [7:0] rx_byte_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  remaining_q, remaining_d;
  logic [7:0]  fill_q, fill_d;
  logic [15:0] countdown_q, countdown_d;
  logic        fits;
  res_t        res;

  // Nine-bit compare so that a depth of 256 never reports a full buffer.
  assign fits = {1'b0, fill_q} < 9'(BufferDepth);

  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    fill_d      = fill_q;
    countdown_d = countdown_q;
    res         = '0;
    if (!kind_i) begin
      unique case (phase_q)
        PH_CMD: begin
          countdown_d = cfg_i.idle_timeout_polls;
          if (rx_byte_i == cfg_i.data_command_code) begin
            phase_d = PH_COUNT;
          end else if (rx_byte_i == cfg_i.function_command_code) begin
            phase_d = PH_FUNC;
          end
        end
        PH_COUNT: begin
          remaining_d = rx_byte_i;
          phase_d     = PH_DATA;
        end
        PH_DATA: begin
          if (fits) begin
            res.write_valid = 1'b1;
            res.write_index = fill_q;
            res.write_byte  = rx_byte_i;
            fill_d          = fill_q + 8'd1;
          end else begin
            res.overrun = 1'b1;
          end
          remaining_d = remaining_q - 8'd1;
          if (remaining_d == 8'd0) begin
            phase_d = PH_CMD;
          end
        end
        PH_FUNC: begin
          res.invoke_valid  = 1'b1;
          res.function_id   = rx_byte_i;
          res.payload_count = fill_q;
          phase_d           = PH_CMD;
          fill_d            = 8'd0;
        end
        default: phase_d = PH_CMD;
      endcase
    end else if (countdown_q != 16'd0) begin
      countdown_d = countdown_q - 16'd1;
    end else begin
      phase_d           = PH_CMD;
      fill_d            = 8'd0;
      res.timeout_reset = 1'b1;
    end
    res.parser_phase = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CMD;
      remaining_q <= 8'd0;
      fill_q      <= 8'd0;
      countdown_q <= 16'd0;
    end else if (advance_i) begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      fill_q      <= fill_d;
      countdown_q <= countdown_d;
    end
  end

  assign res_o = res;

  a_invoke_clears_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res.invoke_valid |=> fill_q == 8'd0)
    else $error("fill index not cleared after invocation");

  a_timeout_to_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res.timeout_reset |=> phase_q == PH_CMD && fill_q == 8'd0)
    else $error("timeout did not return to command phase");

  a_write_bumps_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res.write_valid |=> fill_q == $past(fill_q) + 8'd1)
    else $error("fill index did not advance after a write");

  a_overrun_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.overrun |-> !fits && phase_q == PH_DATA && !res.write_valid)
    else $error("overrun flagged while the buffer had room");

endmodule

// File: rtl/core/cfp_out.sv
// Result register of the command frame parser, holding one beat until taken.
// Depends on cfp_pkg for the res_t struct.
module cfp_out import cfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic out_stall_i,
  output logic out_valid_o,
  output logic free_o,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  // The register can take a new beat when empty or when its beat leaves now.
  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && out_stall_i |=> $stable(res_q) && valid_q)
    else $error("stalled result overwritten");

endmodule
